FILE: design/bpfhm_pkg.sv
// Shared constants and beat types for the bucketed page frame hash map.
package bpfhm_pkg;
  localparam int ROWS      = 256;
  localparam int WAYS      = 4;
  localparam int LINKS     = 2;
  localparam int SLOTS     = WAYS * LINKS;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MOD_W     = 9;
  localparam int PAGE_W    = 32;
  localparam int FRAME_W   = 16;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int DIV_CNT_W = $clog2(PAGE_W);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [MOD_W-1:0] ROWS_RESET = MOD_W'(ROWS);
  localparam logic [MOD_W-1:0] MOD_ONE    = MOD_W'(1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PAGE_W - 1);

  localparam logic [FUNC_W-1:0] FN_GET = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PUT = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DEL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] new_frame;
  } in_beat_t;

  typedef struct packed {
    logic [FRAME_W-1:0] result_frame;
    logic [STAT_W-1:0]  status;
  } out_beat_t;

  typedef struct packed {
    in_beat_t         item;
    logic [ROW_W-1:0] row;
  } qent_t;

  typedef struct packed {
    logic [SLOTS-1:0]              valid;
    logic [SLOTS-1:0][PAGE_W-1:0]  page;
    logic [SLOTS-1:0][FRAME_W-1:0] frame;
  } row_t;
endpackage

FILE: design/bpfhm_front.sv
// Front end: accepts beats and reduces the page to its row, one quotient bit a cycle.
module bpfhm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpfhm_pkg::in_beat_t           in_beat,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpfhm_pkg::MOD_W-1:0]   rows_in_use,
  output bpfhm_pkg::qent_t              q_wdata,
  output logic                          q_push,
  input  logic                          q_full
);
  import bpfhm_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t               state_r, state_nxt;
  in_beat_t              item_r;
  logic [PAGE_W-1:0]     div_r;
  logic [ROW_W-1:0]      rem_r, rem_nxt;
  logic [MOD_W-1:0]      m_r, m_sat;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [ROW_W:0]        trial, m_ext, diff;
  logic                  accept;

  assign in_stall = (state_r != F_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (rows_in_use == '0) begin
      m_sat = MOD_ONE;
    end else if (rows_in_use > ROWS_RESET) begin
      m_sat = ROWS_RESET;
    end else begin
      m_sat = rows_in_use;
    end
  end

  assign trial = {rem_r, div_r[PAGE_W-1]};
  assign m_ext = (ROW_W + 1)'(m_r);
  assign diff  = trial - m_ext;
  assign rem_nxt = (trial >= m_ext) ? diff[ROW_W-1:0] : trial[ROW_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (accept) state_nxt = F_DIV;
      F_DIV:  if (cnt_r == DIV_LAST) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_beat;
      div_r  <= in_beat.page;
      rem_r  <= '0;
      m_r    <= m_sat;
      cnt_r  <= '0;
    end else if (state_r == F_DIV) begin
      div_r <= {div_r[PAGE_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign q_push       = (state_r == F_PUSH) && !q_full;
  assign q_wdata.item = item_r;
  assign q_wdata.row  = rem_r;

  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == F_DIV |-> {1'b0, rem_r} < m_ext)
    else $error("remainder not below modulus");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIV && cnt_r == DIV_LAST) |=> state_r == F_PUSH)
    else $error("division did not finish after last step");
endmodule

FILE: design/bpfhm_fifo.sv
// Two-entry queue between the front end and the table engine.
module bpfhm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bpfhm_pkg::qent_t  wdata,
  output logic              full,
  input  logic              pop,
  output bpfhm_pkg::qent_t  rdata,
  output logic              empty
);
  import bpfhm_pkg::*;

  qent_t             ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
endmodule

FILE: design/bpfhm_back.sv
// Table engine: reads a row, searches its slots, writes back and registers the result.
module bpfhm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpfhm_pkg::qent_t     q_rdata,
  input  logic                 q_empty,
  output logic                 q_pop,
  output bpfhm_pkg::out_beat_t out_beat,
  output logic                 out_valid,
  input  logic                 out_stall
);
  import bpfhm_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EXEC = 2'b10
  } bstate_t;

  bstate_t          state_r, state_nxt;
  row_t             mem [ROWS];
  row_t             rdata_r, wdata;
  qent_t            item_r;
  logic [ROWS-1:0]  row_init_r;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_r, res;
  logic             blocked, exec_go, mem_we;
  logic [SLOTS-1:0] eff_valid;

  assign blocked = out_valid_r && out_stall;
  assign exec_go = (state_r == B_EXEC) && !blocked;
  assign q_pop   = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (q_pop) state_nxt = B_EXEC;
      B_EXEC: if (exec_go) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    logic [SLOTS-1:0]  hit;
    logic              hit_found, emp_found;
    logic [SLOT_W-1:0] hit_idx, emp_idx;
    eff_valid = row_init_r[item_r.row] ? rdata_r.valid : '0;
    hit_found = 1'b0;
    emp_found = 1'b0;
    hit_idx   = '0;
    emp_idx   = '0;
    for (int k = 0; k < SLOTS; k++) begin
      hit[k] = eff_valid[k] && (rdata_r.page[k] == item_r.item.page);
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (!hit_found && hit[k]) begin
        hit_found = 1'b1;
        hit_idx   = SLOT_W'(k);
      end
      if (!emp_found && !eff_valid[k]) begin
        emp_found = 1'b1;
        emp_idx   = SLOT_W'(k);
      end
    end
    wdata              = rdata_r;
    wdata.valid        = eff_valid;
    mem_we             = 1'b0;
    res.result_frame   = '0;
    res.status         = ST_OK;
    case (item_r.item.func)
      FN_GET: begin
        if (hit_found) begin
          res.result_frame = rdata_r.frame[hit_idx];
        end else begin
          res.status = ST_ABSENT;
        end
      end
      FN_PUT: begin
        if (hit_found) begin
          wdata.frame[hit_idx] = item_r.item.new_frame;
          mem_we = exec_go;
        end else if (emp_found) begin
          wdata.valid[emp_idx] = 1'b1;
          wdata.page[emp_idx]  = item_r.item.page;
          wdata.frame[emp_idx] = item_r.item.new_frame;
          mem_we = exec_go;
        end else begin
          res.status = ST_FULL;
        end
      end
      FN_DEL: begin
        if (hit_found) begin
          wdata.valid[hit_idx] = 1'b0;
          res.result_frame     = rdata_r.frame[hit_idx];
          mem_we = exec_go;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      row_init_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) row_init_r[item_r.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r  <= q_rdata;
      rdata_r <= mem[q_rdata.row];
    end
    if (mem_we) mem[item_r.row] <= wdata;
    if (exec_go) out_r <= res;
  end

  assign out_beat  = out_r;
  assign out_valid = out_valid_r;

  a_exec_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r)
    else $error("executed item produced no result beat");
  a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == B_EXEC)
    else $error("popped item not executed");
  a_write_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == B_EXEC && !blocked)
    else $error("table written outside execution");
endmodule

FILE: design/bucketed_page_frame_hash_map_unit.sv
// Top level of the bucketed page frame hash map.
// Maps 32-bit pages to 16-bit frames in 256 rows of 8 slots (4 ways by 2 links). The
// row is page modulo rows_in_use (0 read as 1, above 256 as 256), found by a restoring
// remainder unit that takes one page bit a cycle. The result passes through the
// remainder, the queue, then the table engine (row read, then search, write-back and
// result register). The front end takes the next item in the cycle after its queue
// push and takes none while an item is being reduced or pushed. A stalled result
// holds the table engine. Valid marks read as cleared after reset
// through per-row flags; no clearing pass is needed.
module bucketed_page_frame_hash_map_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bpfhm_pkg::in_beat_t         in_beat,
  input  logic                        in_valid,
  output logic                        in_stall,
  output bpfhm_pkg::out_beat_t        out_beat,
  output logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        cfg_we,
  input  logic [bpfhm_pkg::MOD_W-1:0] cfg_wdata
);
  import bpfhm_pkg::*;

  logic [MOD_W-1:0] rows_in_use_r;
  qent_t            q_wdata, q_rdata;
  logic             q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RESET;
    end else if (cfg_we) begin
      rows_in_use_r <= cfg_wdata;
    end
  end

  bpfhm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_beat     (in_beat),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rows_in_use (rows_in_use_r),
    .q_wdata     (q_wdata),
    .q_push      (q_push),
    .q_full      (q_full)
  );

  bpfhm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bpfhm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_beat  (out_beat),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );
endmodule

FILE: tb/bucketed_page_frame_hash_map_unit_test.sv
// Testbench for the bucketed page frame hash map: directed table plus random traffic.
`timescale 1ns / 100ps
module bucketed_page_frame_hash_map_unit_test;
  import bpfhm_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int N_RANDOM = 1030;
  localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;

  typedef struct {
    in_beat_t beat;
    logic has_exp;
    out_beat_t exp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  in_beat_t in_beat;
  logic in_valid;
  logic in_stall;
  out_beat_t out_beat;
  logic out_valid;
  logic out_stall;
  logic cfg_we;
  logic [MOD_W-1:0] cfg_wdata;

  bucketed_page_frame_hash_map_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_beat(in_beat), .in_valid(in_valid), .in_stall(in_stall),
    .out_beat(out_beat), .out_valid(out_valid), .out_stall(out_stall),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [MOD_W-1:0] map_rows;
  logic map_valid [ROWS*SLOTS];
  logic [PAGE_W-1:0] map_page [ROWS*SLOTS];
  logic [FRAME_W-1:0] map_frame [ROWS*SLOTS];

  out_beat_t pending_q[$];
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int beats_in = 0;
  int beats_out = 0;
  bit quiet = 0;
  logic [PAGE_W-1:0] page_pool[$];

  function automatic out_beat_t map_apply(in_beat_t b);
    int unsigned m;
    int unsigned base;
    int hit;
    int hole;
    out_beat_t r;
    m = map_rows;
    if (m == 0) m = 1;
    if (m > ROWS) m = ROWS;
    base = (b.page % m) * SLOTS;
    hit = -1;
    hole = -1;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (map_valid[base+k] && map_page[base+k] == b.page) hit = base + k;
      if (!map_valid[base+k]) hole = base + k;
    end
    r.result_frame = '0;
    r.status = ST_OK;
    case (b.func)
      FN_GET: begin
        if (hit >= 0) r.result_frame = map_frame[hit];
        else r.status = ST_ABSENT;
      end
      FN_PUT: begin
        if (hit >= 0) map_frame[hit] = b.new_frame;
        else if (hole >= 0) begin
          map_valid[hole] = 1'b1;
          map_page[hole] = b.page;
          map_frame[hole] = b.new_frame;
        end else r.status = ST_FULL;
      end
      FN_DEL: begin
        if (hit >= 0) begin
          map_valid[hit] = 1'b0;
          r.result_frame = map_frame[hit];
        end else r.status = ST_ABSENT;
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall bursts, checking
  int stall_left = 0;
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      beats_out <= beats_out + 1;
      if (pending_q.size() == 0) begin
        $error("unexpected beat: result_frame %0h status %0d",
               out_beat.result_frame, out_beat.status);
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_beat.result_frame !== e.result_frame) begin
          $error("result_frame exp %0h got %0h", e.result_frame, out_beat.result_frame);
          fail_cnt++;
        end
        if (out_beat.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_beat.status);
          fail_cnt++;
        end
      end
    end
    if (!rst_n || quiet) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  task automatic send_beat(in_beat_t b, logic has_exp, out_beat_t exp);
    out_beat_t p;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_beat <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    p = map_apply(b);
    if (has_exp && p !== exp) begin
      $error("table row %0h: predictor gives %0h, typed %0h", b, p, exp);
      fail_cnt++;
    end
    pending_q.push_back(p);
    beats_in++;
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_rows(logic [MOD_W-1:0] v);
    drain_and_idle();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    map_rows = v;
  endtask

  function automatic in_beat_t mk(logic [FUNC_W-1:0] f, logic [PAGE_W-1:0] p,
                                  logic [FRAME_W-1:0] fr);
    in_beat_t b;
    b.func = f;
    b.page = p;
    b.new_frame = fr;
    return b;
  endfunction

  function automatic out_beat_t ob(logic [FRAME_W-1:0] fr, logic [STAT_W-1:0] st);
    out_beat_t o;
    o.result_frame = fr;
    o.status = st;
    return o;
  endfunction

  dir_row_t dir_tab[$];

  initial begin
    in_beat_t b;
    int unsigned pick;
    logic [PAGE_W-1:0] pg;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    map_rows = ROWS_RESET;
    for (int i = 0; i < ROWS * SLOTS; i++) map_valid[i] = 1'b0;

    // after reset all absent; then row 0 filled past capacity, extremes, unused code
    dir_tab.push_back('{mk(FN_GET, 32'h0, 16'h0), 1'b1, ob(16'h0, ST_ABSENT)});
    dir_tab.push_back('{mk(FN_DEL, 32'hFFFF_FFFF, 16'h0), 1'b1, ob(16'h0, ST_ABSENT)});
    for (int i = 0; i < SLOTS; i++)
      dir_tab.push_back('{mk(FN_PUT, 32'(i * ROWS), 16'(16'hFFF0 + i)), 1'b1,
                          ob(16'h0, ST_OK)});
    dir_tab.push_back('{mk(FN_PUT, 32'h800, 16'hABCD), 1'b1, ob(16'h0, ST_FULL)});
    dir_tab.push_back('{mk(FN_GET, 32'h300, 16'h0), 1'b1, ob(16'hFFF3, ST_OK)});
    dir_tab.push_back('{mk(FN_PUT, 32'h300, 16'hFFFF), 1'b1, ob(16'h0, ST_OK)});
    dir_tab.push_back('{mk(FN_DEL, 32'h300, 16'h0), 1'b1, ob(16'hFFFF, ST_OK)});
    dir_tab.push_back('{mk(FN_PUT, 32'h800, 16'h0000), 1'b1, ob(16'h0, ST_OK)});
    dir_tab.push_back('{mk(FN_GET, 32'h800, 16'h1234), 1'b1, ob(16'h0, ST_OK)});
    dir_tab.push_back('{mk(FN_PUT, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, ob(16'h0, ST_OK)});
    dir_tab.push_back('{mk(FN_GET, 32'hFFFF_FFFF, 16'h0), 1'b1, ob(16'hFFFF, ST_OK)});
    dir_tab.push_back('{mk(FN_NOP, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, ob(16'h0, ST_OK)});
    dir_tab.push_back('{mk(FN_GET, 32'hFFFF_FFFF, 16'h0), 1'b1, ob(16'hFFFF, ST_OK)});
    dir_tab.push_back('{mk(FN_GET, 32'h5555_AAAA, 16'h0), 1'b0, ob(16'h0, ST_OK)});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].has_exp, dir_tab[i].exp);

    // modulus change: stored pages now land in other rows; zero and over-range saturate
    set_rows(9'd0);
    send_beat(mk(FN_GET, 32'h800, 16'h0), 1'b0, ob(16'h0, ST_OK));
    send_beat(mk(FN_PUT, 32'h7, 16'h77), 1'b0, ob(16'h0, ST_OK));
    send_beat(mk(FN_GET, 32'h7, 16'h0), 1'b0, ob(16'h0, ST_OK));
    set_rows(9'h1FF);
    send_beat(mk(FN_GET, 32'hFFFF_FFFF, 16'h0), 1'b0, ob(16'h0, ST_OK));
    send_beat(mk(FN_GET, 32'h7, 16'h0), 1'b0, ob(16'h0, ST_OK));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_rows(9'd1);
        1: set_rows(9'd3);
        2: set_rows(9'd256);
        3: set_rows(9'(9'd2 + $urandom_range(0, 250)));
        4: set_rows(9'd257);
        default: set_rows(9'd7);
      endcase
      page_pool.delete();
      for (int i = 0; i < 24; i++) begin
        pg = (i < 20) ? 32'($urandom_range(0, 40)) : $urandom;
        if (i % 5 == 0) pg = pg | 32'h8000_0000 | $urandom;
        page_pool.push_back(pg);
      end
      if (ph == 5) quiet = 1;
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        pick = $urandom_range(0, 99);
        pg = (pick < 85) ? page_pool[$urandom_range(0, page_pool.size() - 1)] : $urandom;
        b.page = pg;
        b.new_frame = 16'($urandom);
        pick = $urandom_range(0, 99);
        b.func = (pick < 45) ? FN_PUT : (pick < 75) ? FN_GET : (pick < 97) ? FN_DEL : FN_NOP;
        send_beat(b, 1'b0, ob(16'h0, ST_OK));
      end
    end

    drain_and_idle();
    $display("Covered %0d beats in, %0d beats out over nine modulus settings,",
             beats_in, beats_out);
    $display("including full rows, updates, removals, unused code and saturated modulus.");
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
